>>> rtl/dlsqp_pkg.sv
`default_nettype none

package dlsqp_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GAIN    = 3'd0,
    REG_DAMPING = 3'd1,
    REG_COST0   = 3'd2,
    REG_COST1   = 3'd3,
    REG_COST2   = 3'd4,
    REG_COST3   = 3'd5,
    REG_COST4   = 3'd6,
    REG_COST5   = 3'd7
  } reg_idx_t;

  localparam int unsigned NUM_COST = 6;

  localparam logic [16:0] GAIN_RST = 17'd65536;
  localparam logic [30:0] COST_RST = 31'd65536;

  // Output kinds
  localparam logic KIND_HESS = 1'b0;
  localparam logic KIND_LIN  = 1'b1;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_LJ,     // cost * jac
    S_LJW,    // store weighted jacobian
    S_LG,     // gain * err
    S_LGN,    // negate, read old weighted error
    S_LC,     // cost * ng
    S_LCW,    // store weighted error
    S_SO,     // old^2
    S_SOA,    // remove old^2 from sum
    S_SN,     // new^2
    S_SNA,    // add new^2 to sum
    S_MU0,    // damping * sum[15:0]
    S_MU1,    // damping * sum[47:16]
    S_MU2,    // damping * sum[63:48]
    S_MU3,    // clamp mu
    S_RD,     // read operands
    S_MUL,    // multiply operands
    S_ACC,    // accumulate
    S_OUT,    // finish entry
    S_WAIT    // hold result until taken
  } state_t;

  // Q16.16 product rounding: add half an LSB and floor
  function automatic logic signed [65:0] rnd16(input logic signed [65:0] p);
    rnd16 = (p + 66'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < -66'sd2147483648) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/damped_least_squares_qp_assembly.sv
// Load: each request is weighted and stored before the next is taken; when col is 0
// the row error is also updated. Final request: its own load, mu in MU0 to MU3, then
// 35 results (for 7 joints), each formed through the single shared multiplier and
// held in the output register until taken.
// Input is not taken while results are emitted.
// Synchronous active-low reset clears control and config; stores are undefined.
`default_nettype none

module damped_least_squares_qp_assembly #(
  parameter int TASK_ROWS  = 6,
  parameter int NUM_JOINTS = 7
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // cfg
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [30:0] cfg_data,
  // in: tdata = row[2:0], col[5:3], jac_value[37:6], err_value[69:38], zeros
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,
  input  wire logic        in_tlast,   // final_item
  // out: tdata = out_row[2:0], out_col[5:3], out_value[37:6], zeros
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,
  output logic             out_tuser,  // kind
  output logic             out_tlast   // end_of_run
);

  localparam int JDEPTH = TASK_ROWS * NUM_JOINTS;
  localparam int JA_W   = (JDEPTH > 1) ? $clog2(JDEPTH) : 1;
  localparam int EA_W   = (TASK_ROWS > 1) ? $clog2(TASK_ROWS) : 1;
  localparam logic [2:0] LAST_K = 3'(TASK_ROWS - 1);
  localparam logic [2:0] LAST_J = 3'(NUM_JOINTS - 1);

  // config registers
  logic [16:0] gain_r;
  logic [30:0] damping_r;
  logic [30:0] cost_r [dlsqp_pkg::NUM_COST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= dlsqp_pkg::GAIN_RST;
      damping_r <= '0;
      for (int n = 0; n < dlsqp_pkg::NUM_COST; n++) cost_r[n] <= dlsqp_pkg::COST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        dlsqp_pkg::REG_GAIN:    gain_r    <= cfg_data[16:0];
        dlsqp_pkg::REG_DAMPING: damping_r <= cfg_data;
        [dlsqp_pkg::REG_COST0:dlsqp_pkg::REG_COST5]:
          cost_r[cfg_index - dlsqp_pkg::REG_COST0] <= cfg_data;
        default: ;
      endcase
    end
  end

  // state
  dlsqp_pkg::state_t state_r, state_nxt;

  // request latch
  logic [2:0]         row_r, col_r;
  logic signed [31:0] jac_r, err_r;
  logic               fin_r;
  logic               pos_ok;

  // arithmetic
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic signed [65:0] prod_rnd;
  logic signed [31:0] ng_r, nw_r;
  logic [63:0]        esum_r;
  logic [63:0]        mu_acc_r;
  logic [32:0]        mu_r;
  logic signed [51:0] acc_r;
  logic [63:0]        mu_tmp;

  // loop counters
  logic [2:0] i_r, j_r, k_r;
  logic       kind_r;
  logic       last_ent;

  // output register
  logic        out_valid_r;
  logic [2:0]  o_row_r, o_col_r;
  logic [31:0] o_val_r;
  logic        o_kind_r, o_last_r;

  // memories
  logic signed [31:0] jmem [JDEPTH];
  logic signed [31:0] emem [TASK_ROWS];
  logic [TASK_ROWS-1:0] e_vld_r;
  logic signed [31:0] ja_rd_r, jb_rd_r, e_rd_r;
  logic               j_we, j_re, e_we, e_re;
  logic [JA_W-1:0]    j_waddr, ja_raddr, jb_raddr;
  logic [EA_W-1:0]    e_waddr, e_raddr;

  logic in_acc, out_acc;
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  assign pos_ok = (in_tdata[2:0] < 3'(TASK_ROWS)) && (in_tdata[5:3] < 3'(NUM_JOINTS));

  assign last_ent = (kind_r == dlsqp_pkg::KIND_LIN) && (i_r == LAST_J);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dlsqp_pkg::S_IDLE:
        if (in_acc) begin
          if (pos_ok)         state_nxt = dlsqp_pkg::S_LJ;
          else if (in_tlast)  state_nxt = dlsqp_pkg::S_MU0;
        end
      dlsqp_pkg::S_LJ:  state_nxt = dlsqp_pkg::S_LJW;
      dlsqp_pkg::S_LJW:
        if (col_r == 3'd0)    state_nxt = dlsqp_pkg::S_LG;
        else if (fin_r)       state_nxt = dlsqp_pkg::S_MU0;
        else                  state_nxt = dlsqp_pkg::S_IDLE;
      dlsqp_pkg::S_LG:  state_nxt = dlsqp_pkg::S_LGN;
      dlsqp_pkg::S_LGN: state_nxt = dlsqp_pkg::S_LC;
      dlsqp_pkg::S_LC:  state_nxt = dlsqp_pkg::S_LCW;
      dlsqp_pkg::S_LCW: state_nxt = dlsqp_pkg::S_SO;
      dlsqp_pkg::S_SO:  state_nxt = dlsqp_pkg::S_SOA;
      dlsqp_pkg::S_SOA: state_nxt = dlsqp_pkg::S_SN;
      dlsqp_pkg::S_SN:  state_nxt = dlsqp_pkg::S_SNA;
      dlsqp_pkg::S_SNA: state_nxt = fin_r ? dlsqp_pkg::S_MU0 : dlsqp_pkg::S_IDLE;
      dlsqp_pkg::S_MU0: state_nxt = dlsqp_pkg::S_MU1;
      dlsqp_pkg::S_MU1: state_nxt = dlsqp_pkg::S_MU2;
      dlsqp_pkg::S_MU2: state_nxt = dlsqp_pkg::S_MU3;
      dlsqp_pkg::S_MU3: state_nxt = dlsqp_pkg::S_RD;
      dlsqp_pkg::S_RD:  state_nxt = dlsqp_pkg::S_MUL;
      dlsqp_pkg::S_MUL: state_nxt = dlsqp_pkg::S_ACC;
      dlsqp_pkg::S_ACC: state_nxt = (k_r == LAST_K) ? dlsqp_pkg::S_OUT : dlsqp_pkg::S_RD;
      dlsqp_pkg::S_OUT: state_nxt = dlsqp_pkg::S_WAIT;
      dlsqp_pkg::S_WAIT:
        if (out_acc) state_nxt = last_ent ? dlsqp_pkg::S_IDLE : dlsqp_pkg::S_RD;
      default: state_nxt = dlsqp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= dlsqp_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    j_we = 1'b0;
    j_re = 1'b0;
    e_we = 1'b0;
    e_re = 1'b0;
    unique case (state_r)
      dlsqp_pkg::S_IDLE: in_tready = 1'b1;
      dlsqp_pkg::S_LJW:  j_we = 1'b1;
      dlsqp_pkg::S_LGN:  e_re = 1'b1;
      dlsqp_pkg::S_LCW:  e_we = 1'b1;
      dlsqp_pkg::S_RD: begin
        j_re = 1'b1;
        e_re = 1'b1;
      end
      default: ;
    endcase
  end

  // memory addresses
  assign j_waddr  = JA_W'(row_r) * JA_W'(NUM_JOINTS) + JA_W'(col_r);
  assign ja_raddr = JA_W'(k_r) * JA_W'(NUM_JOINTS) + JA_W'(i_r);
  assign jb_raddr = JA_W'(k_r) * JA_W'(NUM_JOINTS) + JA_W'(j_r);
  assign e_waddr  = EA_W'(row_r);
  assign e_raddr  = (state_r == dlsqp_pkg::S_RD) ? EA_W'(k_r) : EA_W'(row_r);

  // weighted jacobian store: one write, two reads
  always_ff @(posedge clk) begin
    if (j_we) jmem[j_waddr] <= dlsqp_pkg::sat32(dlsqp_pkg::rnd16(prod_r));
    if (j_re) begin
      ja_rd_r <= jmem[ja_raddr];
      jb_rd_r <= jmem[jb_raddr];
    end
  end

  // row error written flags: a row error never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n)    e_vld_r <= '0;
    else if (e_we) e_vld_r[e_waddr] <= 1'b1;
  end

  // weighted error store; reads and writes fall in separate states
  always_ff @(posedge clk) begin
    if (e_we) emem[e_waddr] <= dlsqp_pkg::sat32(dlsqp_pkg::rnd16(prod_r));
    if (e_re) e_rd_r <= e_vld_r[e_raddr] ? emem[e_raddr] : '0;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      dlsqp_pkg::S_LJ: begin
        mul_a = {2'b00, cost_r[row_r]};
        mul_b = 33'(jac_r);
      end
      dlsqp_pkg::S_LG: begin
        mul_a = {16'd0, gain_r};
        mul_b = 33'(err_r);
      end
      dlsqp_pkg::S_LC: begin
        mul_a = {2'b00, cost_r[row_r]};
        mul_b = 33'(ng_r);
      end
      dlsqp_pkg::S_SO: begin
        mul_a = 33'(e_rd_r);
        mul_b = 33'(e_rd_r);
      end
      dlsqp_pkg::S_SN: begin
        mul_a = 33'(nw_r);
        mul_b = 33'(nw_r);
      end
      dlsqp_pkg::S_MU0: begin
        mul_a = {2'b00, damping_r};
        mul_b = {17'd0, esum_r[15:0]};
      end
      dlsqp_pkg::S_MU1: begin
        mul_a = {2'b00, damping_r};
        mul_b = {1'b0, esum_r[47:16]};
      end
      dlsqp_pkg::S_MU2: begin
        mul_a = {2'b00, damping_r};
        mul_b = {17'd0, esum_r[63:48]};
      end
      dlsqp_pkg::S_MUL: begin
        mul_a = 33'(ja_rd_r);
        mul_b = (kind_r == dlsqp_pkg::KIND_LIN) ? 33'(e_rd_r) : 33'(jb_rd_r);
      end
      default: ;
    endcase
  end

  // rounded product
  assign prod_rnd = dlsqp_pkg::rnd16(prod_r);

  // mu: low part rounded, middle part exact, top part shifted by 32, mod 2^64
  assign mu_tmp = mu_acc_r + {prod_r[31:0], 32'd0};

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      dlsqp_pkg::S_IDLE:
        if (in_acc) begin
          row_r <= in_tdata[2:0];
          col_r <= in_tdata[5:3];
          jac_r <= in_tdata[37:6];
          err_r <= in_tdata[69:38];
          fin_r <= in_tlast;
        end
      dlsqp_pkg::S_LGN: ng_r <= dlsqp_pkg::sat32(-dlsqp_pkg::rnd16(prod_r));
      dlsqp_pkg::S_LCW: nw_r <= dlsqp_pkg::sat32(dlsqp_pkg::rnd16(prod_r));
      dlsqp_pkg::S_MU1: mu_acc_r <= 64'((prod_r + 66'sd32768) >>> 16);
      dlsqp_pkg::S_MU2: mu_acc_r <= mu_acc_r + prod_r[63:0];
      dlsqp_pkg::S_MU3: begin
        mu_r   <= (mu_tmp > 64'h1_0000_0000) ? 33'h1_0000_0000 : mu_tmp[32:0];
        i_r    <= '0;
        j_r    <= '0;
        k_r    <= '0;
        kind_r <= dlsqp_pkg::KIND_HESS;
        acc_r  <= '0;
      end
      dlsqp_pkg::S_ACC: begin
        acc_r <= acc_r + prod_rnd[51:0];
        if (k_r != LAST_K) k_r <= k_r + 3'd1;
      end
      dlsqp_pkg::S_OUT: begin
        o_row_r  <= i_r;
        o_col_r  <= (kind_r == dlsqp_pkg::KIND_LIN) ? 3'd0 : j_r;
        o_kind_r <= kind_r;
        o_last_r <= last_ent;
        if (kind_r == dlsqp_pkg::KIND_LIN)
          o_val_r <= dlsqp_pkg::sat32(-66'(acc_r));
        else if (i_r == j_r)
          o_val_r <= dlsqp_pkg::sat32(66'(acc_r) + 66'(mu_r));
        else
          o_val_r <= dlsqp_pkg::sat32(66'(acc_r));
      end
      dlsqp_pkg::S_WAIT:
        if (out_acc) begin
          acc_r <= '0;
          k_r   <= '0;
          if (kind_r == dlsqp_pkg::KIND_HESS) begin
            if (j_r == LAST_J) begin
              if (i_r == LAST_J) begin
                kind_r <= dlsqp_pkg::KIND_LIN;
                i_r    <= '0;
              end else begin
                i_r <= i_r + 3'd1;
                j_r <= i_r + 3'd1;
              end
            end else begin
              j_r <= j_r + 3'd1;
            end
          end else begin
            i_r <= i_r + 3'd1;
          end
        end
      default: ;
    endcase
  end

  // running squared norm of weighted errors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esum_r <= '0;
    end else if (state_r == dlsqp_pkg::S_SOA) begin
      esum_r <= esum_r - prod_rnd[63:0];
    end else if (state_r == dlsqp_pkg::S_SNA) begin
      esum_r <= esum_r + prod_rnd[63:0];
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n)                           out_valid_r <= 1'b0;
    else if (state_r == dlsqp_pkg::S_OUT) out_valid_r <= 1'b1;
    else if (out_acc)                     out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, o_val_r, o_col_r, o_row_r};
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;

  // checks
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("request taken while result pending");

  a_last_is_linear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser) else $error("end of run on a Hessian entry");

  a_upper_tri: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[5:3] >= out_tdata[2:0]))
    else $error("Hessian entry below diagonal");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(j_we && j_re) && !(e_we && e_re)) else $error("store read and write overlap");

endmodule

`default_nettype wire
